// ----- design/bblru_pkg.sv -----
// package for the byte budget lru cache: widths, status codes
`default_nettype none
package bblru_pkg;
   localparam int unsigned SLOTS_DEF    = 16;
   localparam int unsigned TAG_BITS_DEF = 64;
   localparam int unsigned KEY_W        = 64;
   localparam int unsigned DATA_W       = 32;
   localparam int unsigned CNT_W        = 48;
   localparam int unsigned STATUS_W     = 3;
   localparam int unsigned COUNT_W      = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_STORED  = 3'd2,
      ST_SKIPPED = 3'd3,
      ST_NULL    = 3'd4
   } status_type;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;
endpackage
`default_nettype wire

// ----- design/bblru_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module bblru_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read first (a write returns the old data), read registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ----- design/bblru_top_unused.sv -----
// slot scan comparator: one slot examined per cycle by the sequencer
`default_nettype none
module bblru_scan
   import bblru_pkg::*;
#(
   parameter int unsigned TAG_BITS = TAG_BITS_DEF,
   parameter int unsigned AGE_W    = 4
) (
   input  wire logic                slot_vld,
   input  wire logic [TAG_BITS-1:0] slot_tag,
   input  wire logic [AGE_W-1:0]    slot_age,
   input  wire logic [TAG_BITS-1:0] key,
   input  wire logic [AGE_W-1:0]    best_age,
   input  wire logic                best_any,
   output logic                     tag_match,
   output logic                     older
);
   // tag compare for the find scan, age compare for the oldest-slot scan
   assign tag_match = slot_vld && (slot_tag == key);
   assign older     = slot_vld && (!best_any || (slot_age > best_age));
endmodule
`default_nettype wire

// ----- design/byte_budget_lru_cache_top.sv -----
// byte budget lru cache: sequencer, slot store and counters
//
// Usage: a request on req_* is a lookup or an insert. One response on rsp_*
// follows each request. csr_* writes the byte budget (write only while idle).
// Slots are scanned one per cycle through a single tag/age comparator. A
// rejected or skipped insert goes straight to the response, a lookup miss
// follows a full slot scan and a hit adds a handle read. An insert evicts
// as needed, each eviction a full slot scan, a size read and a budget check.
// The next request is taken in the cycle after the response is loaded.
// The result is built in its own register, so a stalled receiver holds the
// response register while the block takes and works one more request; that
// request then waits with its result until the response register frees.
// Reset clears all valid bits, ages, totals, counters and the budget; slot
// data rams need no clearing since they are read only while valid.
// req_tdata: cmd[0], key_tag[64:1], object_handle[96:65], object_bytes[128:97]
// rsp_tdata: status[2:0], found_handle[34:3], bytes_in_use[66:35],
//            entry_count[71:67], hits_seen[119:72], misses_seen[167:120]
`default_nettype none
module byte_budget_lru_cache_top
   import bblru_pkg::*;
#(
   parameter int unsigned SLOTS    = SLOTS_DEF,
   parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd, key_tag, object_handle, object_bytes from bit 0 up, zero padded
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, found_handle, bytes_in_use, entry_count, hits_seen, misses_seen
   output logic      [167:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);
   localparam int unsigned IW    = $clog2(SLOTS);
   localparam int unsigned AGE_W = $clog2(SLOTS);
   localparam int unsigned CW    = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_DROP, S_CHECK, S_OLDEST, S_EVICT, S_FREE, S_STORE,
      S_LOOKUP, S_RESP
   } state_type;

   state_type               state_ff;
   logic [DATA_W-1:0]       budget_ff;
   logic                    cmd_ff;
   logic [TAG_BITS-1:0]     key_ff;
   logic [DATA_W-1:0]       handle_ff, bytes_ff;
   logic [SLOTS-1:0]        vld_ff;
   logic [AGE_W-1:0]        age_ff [SLOTS];
   logic [TAG_BITS-1:0]     tag_ff [SLOTS];
   logic [DATA_W-1:0]       used_ff;
   logic [CW-1:0]           cnt_ff;
   logic [CNT_W-1:0]        hits_ff, miss_ff;
   logic [IW:0]             idx_ff;
   logic [IW-1:0]           best_ff;
   logic                    any_ff;
   logic                    rd_wait_ff;
   logic                    rsp_v_ff;
   logic [167:0]            rsp_d_ff;
   logic [167:0]            res_ff;

   // size and handle rams, addressed by the sequencer
   logic               ram_we;
   logic [IW-1:0]      ram_addr;
   logic [DATA_W-1:0]  hnd_rd, byt_rd;

   bblru_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_hnd (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(handle_ff),
      .rd_data(hnd_rd));
   bblru_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_byt (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(bytes_ff),
      .rd_data(byt_rd));

   logic [IW-1:0] idx;
   logic          tag_match, older;
   assign idx = idx_ff[IW-1:0];

   bblru_scan #(.TAG_BITS(TAG_BITS), .AGE_W(AGE_W)) u_scan (
      .slot_vld(vld_ff[idx]), .slot_tag(tag_ff[idx]), .slot_age(age_ff[idx]),
      .key(key_ff), .best_age(age_ff[best_ff]), .best_any(any_ff),
      .tag_match(tag_match), .older(older));

   logic          last;
   logic          over;
   logic          accept;
   assign last   = (idx_ff == (IW+1)'(SLOTS - 1));
   assign over   = ({1'b0, used_ff} + {1'b0, bytes_ff}) > {1'b0, budget_ff};
   assign accept = req_tvalid && req_tready;
   assign ram_we = (state_ff == S_STORE) && !rd_wait_ff;
   assign ram_addr = best_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // response packing
   function automatic logic [167:0] pack(input status_type st,
                                         input logic [DATA_W-1:0] fh,
                                         input logic [DATA_W-1:0] used,
                                         input logic [CW-1:0] cnt,
                                         input logic [CNT_W-1:0] h,
                                         input logic [CNT_W-1:0] m);
      pack = {m, h, COUNT_W'(cnt), used, fh, st};
   endfunction

   // sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         budget_ff <= '0;
         vld_ff    <= '0;
         for (int i = 0; i < SLOTS; i++) age_ff[i] <= '0;
         used_ff   <= '0;
         cnt_ff    <= '0;
         hits_ff   <= '0;
         miss_ff   <= '0;
         rsp_v_ff  <= 1'b0;
         idx_ff    <= '0;
         best_ff   <= '0;
         any_ff    <= 1'b0;
         rd_wait_ff <= 1'b0;
      end else begin
         if (rsp_v_ff && rsp_tready && state_ff != S_RESP) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid) budget_ff <= csr_data;
               if (accept) begin
                  cmd_ff    <= req_tdata[0];
                  key_ff    <= req_tdata[TAG_BITS:1];
                  handle_ff <= req_tdata[96:65];
                  bytes_ff  <= req_tdata[128:97];
                  idx_ff    <= '0;
                  any_ff    <= 1'b0;
                  state_ff  <= S_FIND;
               end
            end
            S_FIND: begin
               // reject and skip checks come first for inserts
               if (cmd_ff == CMD_INSERT && handle_ff == '0) begin
                  res_ff   <= pack(ST_NULL, '0, used_ff, cnt_ff, hits_ff, miss_ff);
                  state_ff <= S_RESP;
               end else if (cmd_ff == CMD_INSERT &&
                            (budget_ff == '0 || bytes_ff > budget_ff)) begin
                  res_ff   <= pack(ST_SKIPPED, '0, used_ff, cnt_ff, hits_ff,
                                   miss_ff);
                  state_ff <= S_RESP;
               end else if (tag_match) begin
                  best_ff    <= idx;
                  rd_wait_ff <= 1'b1;
                  state_ff   <= (cmd_ff == CMD_INSERT) ? S_DROP : S_LOOKUP;
               end else if (last) begin
                  if (cmd_ff == CMD_LOOKUP) begin
                     miss_ff  <= miss_ff + 1'b1;
                     res_ff   <= pack(ST_MISS, '0, used_ff, cnt_ff, hits_ff,
                                      miss_ff + 1'b1);
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_LOOKUP: begin
               // wait for handle read, then promote to newest
               if (rd_wait_ff) begin
                  rd_wait_ff <= 1'b0;
               end else begin
                  for (int i = 0; i < SLOTS; i++)
                     if (vld_ff[i] && IW'(i) != best_ff && age_ff[i] < age_ff[best_ff])
                        age_ff[i] <= age_ff[i] + 1'b1;
                  age_ff[best_ff] <= '0;
                  hits_ff  <= hits_ff + 1'b1;
                  res_ff   <= pack(ST_HIT, hnd_rd, used_ff, cnt_ff,
                                   hits_ff + 1'b1, miss_ff);
                  state_ff <= S_RESP;
               end
            end
            S_DROP, S_EVICT: begin
               // remove slot best_ff once its size has been read
               if (rd_wait_ff) begin
                  rd_wait_ff <= 1'b0;
               end else begin
                  for (int i = 0; i < SLOTS; i++)
                     if (vld_ff[i] && IW'(i) != best_ff && age_ff[i] > age_ff[best_ff])
                        age_ff[i] <= age_ff[i] - 1'b1;
                  used_ff         <= used_ff - byt_rd;
                  vld_ff[best_ff] <= 1'b0;
                  age_ff[best_ff] <= '0;
                  cnt_ff          <= cnt_ff - 1'b1;
                  state_ff        <= S_CHECK;
               end
            end
            S_CHECK: begin
               idx_ff <= '0;
               any_ff <= 1'b0;
               if ((!over && cnt_ff != CW'(SLOTS)) || cnt_ff == '0) begin
                  state_ff <= S_FREE;
               end else begin
                  state_ff <= S_OLDEST;
               end
            end
            S_OLDEST: begin
               // one slot per cycle through the shared age compare
               if (older) begin
                  best_ff <= idx;
                  any_ff  <= 1'b1;
               end
               if (last) begin
                  rd_wait_ff <= 1'b1;
                  state_ff   <= S_EVICT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_FREE: begin
               if (!vld_ff[idx]) begin
                  best_ff    <= idx;
                  rd_wait_ff <= 1'b0;
                  state_ff   <= S_STORE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_STORE: begin
               for (int i = 0; i < SLOTS; i++)
                  if (vld_ff[i]) age_ff[i] <= age_ff[i] + 1'b1;
               vld_ff[best_ff] <= 1'b1;
               tag_ff[best_ff] <= key_ff;
               age_ff[best_ff] <= '0;
               used_ff  <= used_ff + bytes_ff;
               cnt_ff   <= cnt_ff + 1'b1;
               res_ff   <= pack(ST_STORED, '0, used_ff + bytes_ff, cnt_ff + 1'b1,
                                hits_ff, miss_ff);
               state_ff <= S_RESP;
            end
            S_RESP: begin
               // load the response register once it is free or being taken
               if (!rsp_v_ff || rsp_tready) begin
                  rsp_d_ff <= res_ff;
                  rsp_v_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the byte budget lru cache: queued driver, monitor, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import bblru_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] obj_bytes;
      logic [31:0] handle;
      logic [63:0] tag;
      logic        cmd;
   } cache_req_type;

   typedef struct packed {
      logic [47:0] misses;
      logic [47:0] hits;
      logic [4:0]  count;
      logic [31:0] used;
      logic [31:0] found;
      status_type  status;
   } cache_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;

   byte_budget_lru_cache_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // cache shadow state
   logic [31:0] budget;
   logic        sh_valid [NSLOT];
   logic [63:0] sh_tag [NSLOT];
   logic [31:0] sh_handle [NSLOT];
   logic [31:0] sh_bytes [NSLOT];
   int          sh_age [NSLOT];
   logic [31:0] sh_used;
   logic [47:0] sh_hits, sh_misses;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int  errors = 0;
   bit  quiet_phase = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 0;
   bit  req_done = 0;
   logic [63:0] tag_pool [8];

   function automatic int lookup_slot(logic [63:0] t);
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_tag[i] == t) return i;
      return -1;
   endfunction

   function automatic int live_count();
      int n = 0;
      for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) n++;
      return n;
   endfunction

   function automatic void evict_slot(int k);
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && i != k && sh_age[i] > sh_age[k]) sh_age[i]--;
      sh_used -= sh_bytes[k];
      sh_valid[k] = 0;
      sh_age[k] = 0;
   endfunction

   // apply one request to the shadow cache and return its response
   function automatic cache_rsp_type cache_predict(cache_req_type r);
      cache_rsp_type o;
      int k, old;
      o.found = '0;
      if (r.cmd == CMD_LOOKUP) begin
         k = lookup_slot(r.tag);
         if (k < 0) begin
            sh_misses++;
            o.status = ST_MISS;
         end else begin
            for (int i = 0; i < NSLOT; i++)
               if (sh_valid[i] && i != k && sh_age[i] < sh_age[k]) sh_age[i]++;
            sh_age[k] = 0;
            o.found = sh_handle[k];
            sh_hits++;
            o.status = ST_HIT;
         end
      end else if (r.handle == 0) begin
         o.status = ST_NULL;
      end else if (budget == 0 || r.obj_bytes > budget) begin
         o.status = ST_SKIPPED;
      end else begin
         k = lookup_slot(r.tag);
         if (k >= 0) evict_slot(k);
         forever begin
            if ({1'b0, sh_used} + {1'b0, r.obj_bytes} <= {1'b0, budget}
                && live_count() < NSLOT) break;
            old = -1;
            for (int i = 0; i < NSLOT; i++)
               if (sh_valid[i] && (old < 0 || sh_age[i] > sh_age[old])) old = i;
            if (old < 0) break;
            evict_slot(old);
         end
         k = -1;
         for (int i = 0; i < NSLOT; i++)
            if (!sh_valid[i] && k < 0) k = i;
         if (k >= 0) begin
            for (int i = 0; i < NSLOT; i++) if (sh_valid[i]) sh_age[i]++;
            sh_valid[k] = 1;
            sh_tag[k] = r.tag;
            sh_handle[k] = r.handle;
            sh_bytes[k] = r.obj_bytes;
            sh_age[k] = 0;
            sh_used += r.obj_bytes;
         end
         o.status = ST_STORED;
      end
      o.used = sh_used;
      o.count = 5'(live_count());
      o.hits = sh_hits;
      o.misses = sh_misses;
      return o;
   endfunction

   // clock
   initial forever #5 clock = ~clock;

   // idle chance in percent, zero during the quiet stretch
   function automatic bit take_gap();
      return !quiet_phase && ($urandom_range(99) < 29);
   endfunction

   // request driver, moves on once the held request was taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_done) begin
            if (pending_reqs.size() > 0 && !take_gap()) begin
               req_tdata <= {7'd0, pending_reqs.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !take_gap();
      end
   end

   // request monitor feeds the predictor
   always @(posedge clock) begin
      req_done <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_rsps.push_back(cache_predict(cache_req_type'(req_tdata[128:0])));
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      cache_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = cache_rsp_type'(rsp_tdata);
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); errors++;
            end
            if (got.found !== want.found) begin
               $error("found_handle exp %h got %h", want.found, got.found); errors++;
            end
            if (got.used !== want.used) begin
               $error("bytes_in_use exp %0d got %0d", want.used, got.used); errors++;
            end
            if (got.count !== want.count) begin
               $error("entry_count exp %0d got %0d", want.count, got.count); errors++;
            end
            if (got.hits !== want.hits) begin
               $error("hits_seen exp %0d got %0d", want.hits, got.hits); errors++;
            end
            if (got.misses !== want.misses) begin
               $error("misses_seen exp %0d got %0d", want.misses, got.misses);
               errors++;
            end
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready) || stimulus_done)
         idle_cycles <= 0;
      else if (pending_reqs.size() > 0 || expected_rsps.size() > 0 || csr_valid)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic cache_req_type mk(logic c, logic [63:0] t, logic [31:0] h,
                                        logic [31:0] b);
      cache_req_type r;
      r.cmd = c; r.tag = t; r.handle = h; r.obj_bytes = b;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_budget(logic [31:0] v);
      wait_drained();
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      budget = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_size(logic [31:0] b);
      case ($urandom_range(9))
         0: return 32'd0;
         1: return b;
         2: return b + 32'd1;
         3: return $urandom();
         default: return (b == 0) ? 32'($urandom_range(50)) : $urandom_range(b / 4);
      endcase
   endfunction

   function automatic cache_req_type rand_req(logic [31:0] b);
      logic [63:0] t;
      logic [31:0] h;
      t = ($urandom_range(9) == 0) ? {$urandom(), $urandom()}
                                   : tag_pool[$urandom_range(7)];
      h = ($urandom_range(12) == 0) ? 32'd0 : $urandom();
      return mk(1'($urandom_range(1)), t, h, rand_size(b));
   endfunction

   // stimulus
   initial begin
      logic [31:0] budgets [6];
      for (int i = 0; i < NSLOT; i++) begin
         sh_valid[i] = 0; sh_tag[i] = '0; sh_handle[i] = '0;
         sh_bytes[i] = '0; sh_age[i] = 0;
      end
      sh_used = '0; sh_hits = '0; sh_misses = '0; budget = '0;
      for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom(), $urandom()};
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // budget zero: inserts skipped, lookups miss, null rejected first
      pending_reqs.push_back(mk(CMD_INSERT, '0, 32'hFFFF_FFFF, 32'd0));
      pending_reqs.push_back(mk(CMD_INSERT, '1, 32'd0, 32'd5));
      pending_reqs.push_back(mk(CMD_LOOKUP, '0, 32'hFFFF_FFFF, '1));
      write_budget(32'hFFFF_FFFF);
      // large budget: zero-size, max-size, full slots, hits, tag replace
      pending_reqs.push_back(mk(CMD_INSERT, '0, 32'd1, 32'd0));
      pending_reqs.push_back(mk(CMD_INSERT, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk(CMD_INSERT, 64'd5, 32'd7, 32'd1));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(mk(CMD_INSERT, 64'(i + 100), 32'(i + 1), 32'd0));
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'd100, '0, '0));
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'd116, '1, '1));
      pending_reqs.push_back(mk(CMD_INSERT, 64'd116, 32'd9, 32'd3));
      // pause until every response is back
      write_budget(32'd1);
      // lowered budget: entries stay until the next stored insert
      pending_reqs.push_back(mk(CMD_LOOKUP, 64'd116, '0, '0));
      pending_reqs.push_back(mk(CMD_INSERT, 64'd7, 32'd3, 32'd2));
      pending_reqs.push_back(mk(CMD_INSERT, 64'd7, 32'd3, 32'd1));

      budgets = '{32'd100, 32'd1000, 32'd0, 32'd40, 32'hFFFF_FFFF, 32'd7};
      for (int p = 0; p < 6; p++) begin
         write_budget(budgets[p]);
         quiet_phase = (p == 3);
         for (int i = 0; i < 325; i++) pending_reqs.push_back(rand_req(budget));
      end
      wait_drained();
      quiet_phase = 0;
      stimulus_done = 1;
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
